@@ rtl/tpc_pkg.sv @@
package tpc_pkg;

    localparam int unsigned SENS_W   = 16;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned STUCK_W  = 16;
    localparam int unsigned READ_W   = 16;
    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 24;

    localparam int unsigned INIT_HIT_COUNT_DEF  = 4;
    localparam int unsigned INIT_IDLE_COUNT_DEF = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_CONFIRM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_ABORT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_HIT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_CONFIRM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_LONG    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_RELEASE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STUCK_LIMIT   = 3'd7;

    localparam logic [SENS_W-1:0]  SENSITIVITY_RST   = 16'd200;
    localparam logic [COUNT_W-1:0] HIT_CONFIRM_RST   = 8'd4;
    localparam logic [COUNT_W-1:0] HIT_ABORT_RST     = 8'd6;
    localparam logic [COUNT_W-1:0] IDLE_HIT_RST      = 8'd5;
    localparam logic [COUNT_W-1:0] IDLE_CONFIRM_RST  = 8'd8;
    localparam logic [COUNT_W-1:0] FIRST_LONG_RST    = 8'd45;
    localparam logic [COUNT_W-1:0] SHORT_RELEASE_RST = 8'd5;
    localparam logic [STUCK_W-1:0] STUCK_LIMIT_RST   = 16'd3125;
    localparam logic [READ_W-1:0]  THRESHOLD_RST     = 16'hFFFF;

    localparam logic [FUNC_W-1:0] FUNC_SAMPLE    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ACK       = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CALIBRATE = 2'd2;

    typedef enum logic [1:0] {
        ST_INIT     = 2'd0,
        ST_HIT      = 2'd1,
        ST_IDLE     = 2'd2,
        ST_IDLE_HIT = 2'd3
    } t_state;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_IDLE  = 2'd1,
        EV_SHORT = 2'd2,
        EV_LONG  = 2'd3
    } t_event;

    typedef struct packed {
        logic [SENS_W-1:0]  sensitivity;
        logic [COUNT_W-1:0] hit_confirm_count;
        logic [COUNT_W-1:0] hit_abort_count;
        logic [COUNT_W-1:0] idle_hit_count;
        logic [COUNT_W-1:0] idle_confirm_count;
        logic [COUNT_W-1:0] first_long_count;
        logic [COUNT_W-1:0] short_release_count;
        logic [STUCK_W-1:0] stuck_limit;
    } t_cfg;

    typedef struct packed {
        logic [READ_W-1:0] touch_threshold;
        logic              recalibrate_request;
        t_event            event_code;
    } t_result;

endpackage

@@ rtl/tpc_cfg.sv @@
module tpc_cfg
    import tpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensitivity         <= SENSITIVITY_RST;
            r_cfg.hit_confirm_count   <= HIT_CONFIRM_RST;
            r_cfg.hit_abort_count     <= HIT_ABORT_RST;
            r_cfg.idle_hit_count      <= IDLE_HIT_RST;
            r_cfg.idle_confirm_count  <= IDLE_CONFIRM_RST;
            r_cfg.first_long_count    <= FIRST_LONG_RST;
            r_cfg.short_release_count <= SHORT_RELEASE_RST;
            r_cfg.stuck_limit         <= STUCK_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SENSITIVITY:   r_cfg.sensitivity         <= i_cfg_wdata;
                REG_HIT_CONFIRM:   r_cfg.hit_confirm_count   <= i_cfg_wdata[COUNT_W-1:0];
                REG_HIT_ABORT:     r_cfg.hit_abort_count     <= i_cfg_wdata[COUNT_W-1:0];
                REG_IDLE_HIT:      r_cfg.idle_hit_count      <= i_cfg_wdata[COUNT_W-1:0];
                REG_IDLE_CONFIRM:  r_cfg.idle_confirm_count  <= i_cfg_wdata[COUNT_W-1:0];
                REG_FIRST_LONG:    r_cfg.first_long_count    <= i_cfg_wdata[COUNT_W-1:0];
                REG_SHORT_RELEASE: r_cfg.short_release_count <= i_cfg_wdata[COUNT_W-1:0];
                REG_STUCK_LIMIT:   r_cfg.stuck_limit         <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/tpc_core.sv @@
module tpc_core
    import tpc_pkg::*;
#(
    parameter int unsigned INIT_HIT_COUNT  = INIT_HIT_COUNT_DEF,
    parameter int unsigned INIT_IDLE_COUNT = INIT_IDLE_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [READ_W-1:0] i_reading,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    localparam logic [COUNT_W-1:0] INIT_HIT  = COUNT_W'(INIT_HIT_COUNT);
    localparam logic [COUNT_W-1:0] INIT_IDLE = COUNT_W'(INIT_IDLE_COUNT);
    localparam logic [COUNT_W-1:0] TALLY_MAX = '1;

    t_state              r_state, n_state;
    logic [COUNT_W-1:0]  r_hit, n_hit;
    logic [COUNT_W-1:0]  r_idle, n_idle;
    logic [STUCK_W-1:0]  r_stuck, n_stuck;
    logic [READ_W-1:0]   r_thr, n_thr;
    logic                r_pend, n_pend;

    logic                w_run;
    logic                w_is_hit;
    logic [COUNT_W-1:0]  w_hit_inc;
    logic [COUNT_W-1:0]  w_idle_inc;
    logic [STUCK_W-1:0]  w_stuck_inc;
    logic                w_stuck_met;
    logic [READ_W:0]     w_cal_sum;
    logic                w_go;
    logic                w_clr_stuck;
    logic                w_hit_long;
    t_event              w_ev;
    logic                w_req;

    assign w_run       = i_valid && (i_func == FUNC_SAMPLE) && !r_pend;
    assign w_is_hit    = i_reading > r_thr;
    assign w_hit_inc   = (w_is_hit && r_hit != TALLY_MAX) ? r_hit + 1'b1 : r_hit;
    assign w_idle_inc  = (!w_is_hit && r_idle != TALLY_MAX) ? r_idle + 1'b1 : r_idle;
    assign w_stuck_inc = r_stuck + 1'b1;
    assign w_stuck_met = (i_cfg.stuck_limit != '0) && (w_stuck_inc == i_cfg.stuck_limit);
    assign w_cal_sum   = {1'b0, i_reading} + {1'b0, i_cfg.sensitivity};

    // Next state, with the event that the transition reports.
    always_comb begin
        n_state     = r_state;
        w_go        = 1'b0;
        w_clr_stuck = 1'b0;
        w_hit_long  = 1'b0;
        w_ev        = EV_NONE;
        if (w_run) begin
            unique case (r_state)
                ST_INIT: begin
                    if (w_hit_inc >= INIT_HIT) begin
                        n_state = ST_HIT;
                        w_go    = 1'b1;
                    end else if (w_idle_inc >= INIT_IDLE) begin
                        n_state     = ST_IDLE;
                        w_go        = 1'b1;
                        w_clr_stuck = 1'b1;
                    end
                end
                ST_HIT: begin
                    if (w_hit_inc >= i_cfg.hit_confirm_count) begin
                        n_state    = w_stuck_met ? ST_IDLE : ST_INIT;
                        w_go       = 1'b1;
                        w_hit_long = 1'b1;
                        w_ev       = EV_LONG;
                    end else if (w_idle_inc >= i_cfg.hit_abort_count) begin
                        n_state = ST_INIT;
                        w_go    = 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (w_hit_inc >= i_cfg.idle_hit_count) begin
                        n_state = ST_IDLE_HIT;
                        w_go    = 1'b1;
                    end else if (w_idle_inc >= i_cfg.idle_confirm_count) begin
                        n_state = ST_INIT;
                        w_go    = 1'b1;
                        w_ev    = EV_IDLE;
                    end
                end
                ST_IDLE_HIT: begin
                    if (w_hit_inc >= i_cfg.first_long_count) begin
                        n_state = ST_INIT;
                        w_go    = 1'b1;
                        w_ev    = EV_LONG;
                    end else if (w_idle_inc >= i_cfg.short_release_count) begin
                        n_state = ST_INIT;
                        w_go    = 1'b1;
                        w_ev    = EV_SHORT;
                    end
                end
                default: ;
            endcase
        end
    end

    // Tallies, threshold, pending flag and recalibration request.
    always_comb begin
        n_hit   = r_hit;
        n_idle  = r_idle;
        n_stuck = r_stuck;
        n_thr   = r_thr;
        n_pend  = r_pend;
        w_req   = 1'b0;
        if (i_valid && i_func == FUNC_ACK) begin
            n_pend = 1'b0;
        end
        if (i_valid && i_func == FUNC_CALIBRATE) begin
            n_thr = w_cal_sum[READ_W] ? '1 : w_cal_sum[READ_W-1:0];
        end
        if (w_run) begin
            n_hit  = w_go ? '0 : w_hit_inc;
            n_idle = w_go ? '0 : w_idle_inc;
            if (w_ev != EV_NONE) begin
                n_pend = 1'b1;
            end
            if (w_clr_stuck) begin
                n_stuck = '0;
            end
            if (w_hit_long) begin
                if (w_stuck_met) begin
                    n_stuck = '0;
                    if (r_thr > i_cfg.sensitivity) begin
                        n_thr = r_thr - i_cfg.sensitivity;
                    end else begin
                        w_req = 1'b1;
                    end
                end else begin
                    n_stuck = w_stuck_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_hit   <= '0;
            r_idle  <= '0;
            r_stuck <= '0;
            r_thr   <= THRESHOLD_RST;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hit   <= n_hit;
            r_idle  <= n_idle;
            r_stuck <= n_stuck;
            r_thr   <= n_thr;
            r_pend  <= n_pend;
        end
    end

    assign o_result.touch_threshold     = n_thr;
    assign o_result.recalibrate_request = w_req;
    assign o_result.event_code          = w_ev;

endmodule

@@ rtl/touch_press_classifier.sv @@
// Touch press classifier.
// Input words arrive on the s_axis channel: func in tdata[1:0] (sample,
// acknowledge or calibrate) and the electrode reading in tdata[17:2].
// Every input word produces exactly one result word on the m_axis channel:
// event code in tdata[1:0], recalibration request in tdata[2] and the
// threshold after the word in tdata[18:3].
// Sensitivity, counts and stuck limit are written through the write port
// (i_cfg_we, i_cfg_addr, i_cfg_wdata); the user must do so only while no
// word is in flight, as the block does not enforce it. A word accepted
// into the input register is classified out of it, and its result is valid
// on m_axis from the result register; one word can be taken every cycle
// while m_axis does not stall, as the press state is updated per word.
// When the receiver stalls, the result register holds its word and the
// input register fills; s_axis_tready then drops until m_axis drains.
// Reset clears both pipeline stages, the press state, the tallies and the
// pending flag, sets the threshold to its maximum and loads default counts.
module touch_press_classifier
    import tpc_pkg::*;
#(
    parameter int unsigned INIT_HIT_COUNT  = INIT_HIT_COUNT_DEF,
    parameter int unsigned INIT_IDLE_COUNT = INIT_IDLE_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0: func[1:0], reading[17:2], zero padding[23:18].
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Fields from bit 0: event_code[1:0], recalibrate_request[2],
    // touch_threshold[18:3], zero padding[23:19].
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic              r_in_valid;
    logic [FUNC_W-1:0] r_in_func;
    logic [READ_W-1:0] r_in_reading;
    logic              r_out_valid;
    t_result           r_out;
    logic              w_adv;
    logic              w_take;
    t_cfg              w_cfg;
    t_result           w_result;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_func    <= s_axis_tdata[FUNC_W-1:0];
            r_in_reading <= s_axis_tdata[FUNC_W+READ_W-1:FUNC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    tpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    tpc_core #(
        .INIT_HIT_COUNT  (INIT_HIT_COUNT),
        .INIT_IDLE_COUNT (INIT_IDLE_COUNT)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_adv),
        .i_func    (r_in_func),
        .i_reading (r_in_reading),
        .i_cfg     (w_cfg),
        .o_result  (w_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - $bits(t_result))'(0), r_out};

endmodule

@@ rtl/tpc_checker.sv @@
module tpc_checker
    import tpc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result word stays on the bus unchanged.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // Input backpressure only ever comes from a stalled output.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // Right after reset both pipeline stages are empty.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> s_axis_tready && !m_axis_tvalid)
        else $error("pipeline not empty after reset");

    // A recalibration request only comes with a long push.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == EV_LONG)
        else $error("recalibration request without long push");

endmodule

bind touch_press_classifier tpc_checker u_tpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
